### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the LZSS stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### hw/rtl/lzsd_pkg.sv
// Shared constants and controller/datapath handoff types of the LZSS stream decoder.
package lzsd_pkg;

  localparam int POSITION_BITS_DEF = 11;
  localparam int LENGTH_BITS_DEF   = 5;
  localparam int BYTE_W            = 8;
  localparam int LIT_BITS          = 8;
  localparam int SHIFT_CNT_W       = $clog2(BYTE_W);
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new input item
    logic shift;     // consume one stream bit
    logic init;      // return window pointer and token state to reset values
    logic clr_wr;    // write one space into the window during the clearing pass
    logic lit_out;   // emit the gathered literal
    logic cp_rd;     // read the next copy source byte
    logic cp_out;    // emit the copy byte just read
    logic mark_out;  // emit the bare end marker
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_last;  // the bit being consumed is the last of the item
    logic tok_done;    // a token completed within the current item
    logic tok_lit;     // the completed token is a literal
    logic last;        // the current item ends the stream
    logic out_free;    // the result register can take a new item
    logic copy_final;  // the copy byte in flight is the last of its run
    logic clr_done;    // the clearing pass writes its final entry
  } dp_status_t;

endpackage

### hw/rtl/lzsd_in_if.sv
// Input channel of the LZSS stream decoder: compressed bytes.
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

### hw/rtl/lzsd_out_if.sv
// Result channel of the LZSS stream decoder: decoded bytes and end flags.
interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output stream_end, input ready);
  modport sink (input valid, input out_byte, input has_byte, input run_last,
                input stream_end, output ready);
endinterface

### hw/rtl/lzsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/lzsd_datapath.sv
// Datapath of the LZSS stream decoder: bit parser, history window and result register.
`include "assert_macros.svh"

module lzsd_datapath #(
  parameter int POSITION_BITS = lzsd_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = lzsd_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lzsd_pkg::dp_cmd_t     cmd,
  output lzsd_pkg::dp_status_t  sts,
  input  logic [7:0]            in_byte,
  input  logic                  last_byte,
  lzsd_out_if.source            out_ch
);

  localparam int TOK_W     = POSITION_BITS + LENGTH_BITS;
  localparam int CNT_W     = $clog2(TOK_W + 1);
  localparam int RUN_W     = LENGTH_BITS + 1;
  localparam int DEPTH     = 1 << POSITION_BITS;
  localparam int START_POS = DEPTH - ((1 << LENGTH_BITS) + 1);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_LIT   = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;

  logic [7:0]                       byte_r;
  logic                             last_r;
  logic [lzsd_pkg::SHIFT_CNT_W-1:0] shift_cnt_r;
  logic [1:0]                       phase_r;
  logic [TOK_W-1:0]                 tok_bits_r;
  logic [CNT_W-1:0]                 tok_cnt_r;
  logic                             done_v_r;
  logic                             done_lit_r;
  logic [7:0]                       done_data_r;
  logic [POSITION_BITS-1:0]         done_pos_r;
  logic [LENGTH_BITS-1:0]           done_len_r;
  logic [RUN_W-1:0]                 copy_k_r;
  logic [POSITION_BITS-1:0]         wp_r;
  logic [POSITION_BITS-1:0]         clr_cnt_r;
  logic                             out_valid_r;
  logic [7:0]                       out_byte_r;
  logic                             out_has_r;
  logic                             out_run_last_r;
  logic                             out_end_r;

  logic                     bit_in;
  logic [TOK_W-1:0]         tok_bits_sh;
  logic [CNT_W-1:0]         tok_cnt_inc;
  logic                     lit_hit;
  logic                     match_hit;
  logic                     copy_final;
  logic                     out_load;
  logic                     out_free;
  logic                     ram_we;
  logic [POSITION_BITS-1:0] ram_waddr;
  logic [7:0]               ram_wdata;
  logic [POSITION_BITS-1:0] ram_raddr;
  logic [7:0]               ram_rdata;

  // Bits leave the item most significant first.
  assign bit_in      = byte_r[7];
  assign tok_bits_sh = {tok_bits_r[TOK_W-2:0], bit_in};
  assign tok_cnt_inc = tok_cnt_r + 1'b1;
  assign lit_hit     = (phase_r == PH_LIT) && (tok_cnt_inc == CNT_W'(lzsd_pkg::LIT_BITS));
  assign match_hit   = (phase_r == PH_MATCH) && (tok_cnt_inc == CNT_W'(TOK_W));

  assign copy_final = (copy_k_r == ({1'b0, done_len_r} + RUN_W'(1)));
  assign out_load   = cmd.lit_out | cmd.cp_out | cmd.mark_out;
  assign out_free   = !out_valid_r || out_ch.ready;

  // One write port shared by the clearing pass and every emitted byte.
  assign ram_we    = cmd.clr_wr | cmd.lit_out | cmd.cp_out;
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : wp_r;
  assign ram_wdata = cmd.clr_wr  ? lzsd_pkg::SPACE_CHAR :
                     cmd.lit_out ? done_data_r : ram_rdata;
  assign ram_raddr = done_pos_r + POSITION_BITS'(copy_k_r);

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.cp_rd),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_cnt_r <= '0;
      phase_r     <= PH_FLAG;
      tok_cnt_r   <= '0;
      done_v_r    <= 1'b0;
      done_lit_r  <= 1'b0;
      copy_k_r    <= '0;
      wp_r        <= POSITION_BITS'(START_POS);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        shift_cnt_r <= '0;
        done_v_r    <= 1'b0;
        copy_k_r    <= '0;
      end
      if (cmd.shift) begin
        shift_cnt_r <= shift_cnt_r + 1'b1;
        if (phase_r == PH_FLAG) begin
          phase_r   <= bit_in ? PH_LIT : PH_MATCH;
          tok_cnt_r <= '0;
        end else begin
          tok_cnt_r <= tok_cnt_inc;
          if (lit_hit || match_hit) begin
            phase_r    <= PH_FLAG;
            done_v_r   <= 1'b1;
            done_lit_r <= lit_hit;
          end
        end
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // Rewind the pointer on the final byte of a stream instead of advancing it.
      if (cmd.init) begin
        wp_r <= POSITION_BITS'(START_POS);
      end else if (cmd.lit_out || cmd.cp_out) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd.cp_out) begin
        copy_k_r <= copy_k_r + 1'b1;
      end
      if (cmd.init) begin
        phase_r   <= PH_FLAG;
        tok_cnt_r <= '0;
        done_v_r  <= 1'b0;
        clr_cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      last_r <= last_byte;
    end else if (cmd.shift) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
    if (cmd.shift) begin
      tok_bits_r <= (phase_r == PH_FLAG) ? '0 : tok_bits_sh;
      if (lit_hit) begin
        done_data_r <= tok_bits_sh[7:0];
      end
      if (match_hit) begin
        done_pos_r <= tok_bits_sh[TOK_W-1:LENGTH_BITS];
        done_len_r <= tok_bits_sh[LENGTH_BITS-1:0];
      end
    end
    if (cmd.lit_out) begin
      out_byte_r     <= done_data_r;
      out_has_r      <= 1'b1;
      out_run_last_r <= 1'b1;
      out_end_r      <= last_r;
    end else if (cmd.cp_out) begin
      out_byte_r     <= ram_rdata;
      out_has_r      <= 1'b1;
      out_run_last_r <= copy_final;
      out_end_r      <= copy_final & last_r;
    end else if (cmd.mark_out) begin
      out_byte_r     <= '0;
      out_has_r      <= 1'b0;
      out_run_last_r <= 1'b1;
      out_end_r      <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.has_byte   = out_has_r;
  assign out_ch.run_last   = out_run_last_r;
  assign out_ch.stream_end = out_end_r;

  assign sts.shift_last = (shift_cnt_r == lzsd_pkg::SHIFT_CNT_W'(lzsd_pkg::BYTE_W - 1));
  assign sts.tok_done   = done_v_r;
  assign sts.tok_lit    = done_lit_r;
  assign sts.last       = last_r;
  assign sts.out_free   = out_free;
  assign sts.copy_final = copy_final;
  assign sts.clr_done   = (clr_cnt_r == POSITION_BITS'(DEPTH - 1));

  `ASSERT_PROP(a_no_overwrite, clk, rst_n,
    (out_load && out_valid_r) |-> out_ch.ready, "result overwritten before it was taken")
  `ASSERT_PROP(a_one_writer, clk, rst_n,
    $onehot0({cmd.clr_wr, cmd.lit_out, cmd.cp_out}), "window write port driven by two sources")

endmodule

### hw/rtl/lzsd_ctrl.sv
// Controller state machine of the LZSS stream decoder.
`include "assert_macros.svh"

module lzsd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lzsd_pkg::dp_status_t sts,
  output lzsd_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_DISPATCH = 3'd3;
  localparam logic [2:0] S_LIT      = 3'd4;
  localparam logic [2:0] S_CRD      = 3'd5;
  localparam logic [2:0] S_CWR      = 3'd6;
  localparam logic [2:0] S_MARK     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.tok_done) begin
          state_nxt = sts.tok_lit ? S_LIT : S_CRD;
        end else if (sts.last) begin
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.lit_out = 1'b1;
          cmd.init    = sts.last;
          state_nxt   = sts.last ? S_CLEAR : S_IDLE;
        end
      end
      S_CRD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        // Write back before the next read so overlapping copies see fresh bytes.
        if (sts.out_free) begin
          cmd.cp_out = 1'b1;
          if (sts.copy_final) begin
            cmd.init  = sts.last;
            state_nxt = sts.last ? S_CLEAR : S_IDLE;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end
      S_MARK: begin
        if (sts.out_free) begin
          cmd.mark_out = 1'b1;
          cmd.init     = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_PROP(a_accept_shifts, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_SHIFT), "accepted item did not start parsing")
  `ASSERT_PROP(a_dispatch_after_bits, clk, rst_n, (state_r == S_DISPATCH) |-> $past(sts.shift_last), "dispatch before all bits were parsed")
  `ASSERT_NEVER(a_no_emit_in_clear, clk, rst_n, (state_r == S_CLEAR) && (cmd.lit_out || cmd.cp_out || cmd.mark_out), "result emitted during clearing pass")

endmodule

### hw/rtl/lzss_stream_decoder_core.sv
// Top level of the LZSS stream decoder.
//
// in_ch carries compressed bytes (in_byte, read most significant bit first) and
// last_byte, which marks the final byte of a stream. out_ch carries one decoded
// byte per item with has_byte, run_last (last result caused by that input byte)
// and stream_end (last result of the stream). A stream with trailing bits that
// finish no token ends with a bare marker item: has_byte low, both flags high.
// An input byte is parsed in steps: accept, one shift per bit, then dispatch;
// a literal is then emitted directly, while each copy byte is first read from
// the history window RAM and then written back and emitted, in turn.
// A match of length field L copies L+2 bytes.
// After reset, and after every byte with last_byte set, the window is refilled
// with spaces at one entry per cycle, 2^POSITION_BITS entries (2048 by default);
// in_ch is not ready meanwhile, and results already held stay on out_ch.
// A stall on out_ch holds the pending item in the result register and pauses
// the decoder at its next result; nothing is dropped.
module lzss_stream_decoder_core #(
  parameter int POSITION_BITS = lzsd_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = lzsd_pkg::LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lzsd_in_if.sink    in_ch,
  lzsd_out_if.source out_ch
);

  lzsd_pkg::dp_cmd_t    cmd;
  lzsd_pkg::dp_status_t sts;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzsd_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_ch.in_byte),
    .last_byte (in_ch.last_byte),
    .out_ch    (out_ch)
  );

endmodule
